>>> src/phr_enum_pkg.sv
// Shared constants, command and status types, and alphabet functions of the phrase enumerator.
`default_nettype none

package phr_enum_pkg;

    localparam int MAX_PHRASE_LENGTH = 16;

    localparam int VAL_W     = 64;
    localparam int LEN_W     = 5;
    localparam int SEL_W     = 2;
    localparam int CHAR_W    = 7;
    localparam int RADIX_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    // The power sum runs over lengths 0 .. MAX_PHRASE_LENGTH + 1.
    localparam int STEP_W = $clog2(MAX_PHRASE_LENGTH + 2);
    localparam int NCH_W  = $clog2(MAX_PHRASE_LENGTH + 1);

    localparam int BITS_PER_STEP = 8;
    localparam int DIV_STEPS     = VAL_W / BITS_PER_STEP;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 2'd2;

    localparam logic [SEL_W-1:0] ALPHA_DIGITS  = 2'd0;
    localparam logic [SEL_W-1:0] ALPHA_LETTERS = 2'd1;
    localparam logic [SEL_W-1:0] ALPHA_ALNUM   = 2'd2;
    localparam logic [SEL_W-1:0] ALPHA_ASCII   = 2'd3;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 5'd8;

    typedef struct packed {
        logic              rc_clear;
        logic              rc_step;
        logic [STEP_W-1:0] rc_index;
        logic              rc_finish;
        logic              load_index;
        logic              check;
        logic              load_digit;
        logic              div_step;
        logic              emit_char;
        logic              emit_flag;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic flag_result;
        logic last_char;
    } t_dp_status;

    function automatic logic [RADIX_W-1:0] radix_of(input logic [SEL_W-1:0] sel);
        logic [RADIX_W-1:0] k;
        unique case (sel)
            ALPHA_DIGITS:  k = 7'd10;
            ALPHA_LETTERS: k = 7'd52;
            ALPHA_ALNUM:   k = 7'd62;
            default:       k = 7'd95;
        endcase
        return k;
    endfunction

    // The digit is always below the radix of the selected alphabet.
    function automatic logic [CHAR_W-1:0] char_of(input logic [SEL_W-1:0] sel,
                                                  input logic [RADIX_W-1:0] digit);
        logic [CHAR_W-1:0] c;
        unique case (sel)
            ALPHA_DIGITS: begin
                c = digit + 7'h30;
            end
            ALPHA_LETTERS: begin
                c = (digit < 7'd26) ? digit + 7'h41 : digit + 7'h47;
            end
            ALPHA_ALNUM: begin
                if (digit < 7'd10) begin
                    c = digit + 7'h30;
                end else if (digit < 7'd36) begin
                    c = digit + 7'h37;
                end else begin
                    c = digit + 7'h3D;
                end
            end
            default: begin
                c = digit + 7'h20;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/phr_enum_dp.sv
// Datapath: configuration, power sums, byte-wise division by the radix and the output register.
`default_nettype none

module phr_enum_dp import phr_enum_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_status                o_status,
    input  wire logic [VAL_W-1:0]     i_candidate_index,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [CHAR_W-1:0]         o_phrase_char,
    output logic                      o_last_char,
    output logic                      o_empty_phrase,
    output logic                      o_out_of_range
);

    logic [SEL_W-1:0]   r_alpha_sel;
    logic [LEN_W-1:0]   r_min_len;
    logic [LEN_W-1:0]   r_max_len;
    logic [VAL_W-1:0]   r_sum;
    logic [VAL_W-1:0]   r_pw;
    logic               r_pw_sat;
    logic [VAL_W-1:0]   r_start;
    logic [VAL_W-1:0]   r_total;
    logic [VAL_W-1:0]   r_count;
    logic [VAL_W-1:0]   r_val;
    logic [RADIX_W-1:0] r_rem;
    logic [NCH_W-1:0]   r_nchar;
    logic               r_oor;
    logic               r_empty;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;
    logic               r_out_empty;
    logic               r_out_oor;

    logic [RADIX_W-1:0]         radix;
    logic [LEN_W-1:0]           lo_len;
    logic [LEN_W-1:0]           hi_len;
    logic [STEP_W-1:0]          lo_step;
    logic [STEP_W-1:0]          hi_step;
    logic [VAL_W+RADIX_W-1:0]   pw_prod;
    logic [VAL_W:0]             sum_ext;
    logic [VAL_W-1:0]           sum_next;
    logic [RADIX_W:0]           div_trial;
    logic [RADIX_W-1:0]         div_rem;
    logic [BITS_PER_STEP-1:0]   div_q;
    logic                       in_range;
    logic                       sum_zero;
    logic                       out_free;
    logic                       is_last;

    assign radix   = radix_of(r_alpha_sel);
    assign lo_len  = (r_min_len > LEN_W'(MAX_PHRASE_LENGTH)) ? LEN_W'(MAX_PHRASE_LENGTH)
                                                              : r_min_len;
    assign hi_len  = (r_max_len > LEN_W'(MAX_PHRASE_LENGTH)) ? LEN_W'(MAX_PHRASE_LENGTH)
                                                              : r_max_len;
    assign lo_step = STEP_W'(lo_len);
    assign hi_step = STEP_W'(hi_len) + STEP_W'(1);

    assign pw_prod  = {{RADIX_W{1'b0}}, r_pw} * {{VAL_W{1'b0}}, radix};
    assign sum_ext  = {1'b0, r_sum} + {1'b0, r_pw};
    // Once the power has overflowed, every further sum is saturated.
    assign sum_next = (r_pw_sat || sum_ext[VAL_W]) ? {VAL_W{1'b1}} : sum_ext[VAL_W-1:0];

    // Restoring division of the top byte of the working value, one quotient bit per loop iteration.
    always_comb begin
        div_rem   = r_rem;
        div_q     = '0;
        div_trial = '0;
        for (int i = BITS_PER_STEP - 1; i >= 0; i--) begin
            div_trial = {div_rem, r_val[VAL_W-BITS_PER_STEP+i]};
            if (div_trial >= {1'b0, radix}) begin
                div_rem  = RADIX_W'(div_trial - {1'b0, radix});
                div_q[i] = 1'b1;
            end else begin
                div_rem = RADIX_W'(div_trial);
            end
        end
    end

    assign in_range = r_val < r_count;
    assign sum_zero = (r_val == '0) && (r_start == '0);
    assign out_free = !r_out_valid || !i_out_stall;
    assign is_last  = (r_val == '0) || (r_nchar == NCH_W'(MAX_PHRASE_LENGTH));

    assign o_status.out_free    = out_free;
    assign o_status.flag_result = !in_range || sum_zero;
    assign o_status.last_char   = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_sel <= ALPHA_DIGITS;
            r_min_len   <= '0;
            r_max_len   <= MAX_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ALPHABET: r_alpha_sel <= i_cfg_data[SEL_W-1:0];
                CFG_MIN_LEN:  r_min_len   <= i_cfg_data[LEN_W-1:0];
                CFG_MAX_LEN:  r_max_len   <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_total <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.rc_step) begin
                if (i_cmd.rc_index == lo_step) begin
                    r_start <= r_sum;
                end
                if (i_cmd.rc_index == hi_step) begin
                    r_total <= r_sum;
                end
            end
            if (i_cmd.rc_finish) begin
                r_count <= (hi_len < lo_len) ? '0 : r_total - r_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rc_clear) begin
            r_sum    <= '0;
            r_pw     <= VAL_W'(1);
            r_pw_sat <= 1'b0;
        end else if (i_cmd.rc_step) begin
            r_sum    <= sum_next;
            r_pw     <= pw_prod[VAL_W-1:0];
            r_pw_sat <= r_pw_sat || (|pw_prod[VAL_W+RADIX_W-1:VAL_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_index) begin
            r_val <= i_candidate_index;
        end else if (i_cmd.check) begin
            r_val   <= r_val + r_start;
            r_oor   <= !in_range;
            r_empty <= in_range && sum_zero;
            r_nchar <= '0;
        end else if (i_cmd.load_digit) begin
            r_val   <= r_val - VAL_W'(1);
            r_rem   <= '0;
            r_nchar <= r_nchar + NCH_W'(1);
        end else if (i_cmd.div_step) begin
            r_val <= {r_val[VAL_W-BITS_PER_STEP-1:0], div_q};
            r_rem <= div_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_char || i_cmd.emit_flag) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_char) begin
            r_out_char  <= char_of(r_alpha_sel, r_rem);
            r_out_last  <= is_last;
            r_out_empty <= 1'b0;
            r_out_oor   <= 1'b0;
        end else if (i_cmd.emit_flag) begin
            r_out_char  <= '0;
            r_out_last  <= 1'b1;
            r_out_empty <= r_empty;
            r_out_oor   <= r_oor;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_phrase_char  = r_out_char;
    assign o_last_char    = r_out_last;
    assign o_empty_phrase = r_out_empty;
    assign o_out_of_range = r_out_oor;

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_char || i_cmd.emit_flag) |-> o_status.out_free)
        else $error("result written while the output register was still occupied");

    a_flag_result_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_empty || r_out_oor)) |-> (r_out_char == '0 && r_out_last))
        else $error("flagged result carries a character or is not marked last");

    a_digit_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_char |-> (r_rem < radix))
        else $error("division remainder not below the radix");

endmodule

`default_nettype wire

>>> src/phr_enum_ctrl.sv
// Controller: sequences the power-sum recompute, the range check and the per-character division steps.
`default_nettype none

module phr_enum_ctrl import phr_enum_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_status i_status
);

    localparam int STATE_W = 4;
    localparam logic [STATE_W-1:0] S_CLR   = 4'd0;
    localparam logic [STATE_W-1:0] S_RC    = 4'd1;
    localparam logic [STATE_W-1:0] S_FIN   = 4'd2;
    localparam logic [STATE_W-1:0] S_IDLE  = 4'd3;
    localparam logic [STATE_W-1:0] S_CHECK = 4'd4;
    localparam logic [STATE_W-1:0] S_FLAG  = 4'd5;
    localparam logic [STATE_W-1:0] S_LOAD  = 4'd6;
    localparam logic [STATE_W-1:0] S_DIV   = 4'd7;
    localparam logic [STATE_W-1:0] S_EMIT  = 4'd8;

    logic [STATE_W-1:0]   r_state;
    logic [STATE_W-1:0]   n_state;
    logic [STEP_W-1:0]    r_step;
    logic [STEP_W-1:0]    n_step;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [DIV_CNT_W-1:0] n_div_cnt;

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        n_div_cnt      = r_div_cnt;
        o_cmd          = '0;
        o_cmd.rc_index = r_step;
        unique case (r_state)
            S_CLR: begin
                o_cmd.rc_clear = 1'b1;
                n_step         = '0;
                n_state        = S_RC;
            end
            S_RC: begin
                o_cmd.rc_step = 1'b1;
                if (r_step == STEP_W'(MAX_PHRASE_LENGTH + 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_FIN: begin
                o_cmd.rc_finish = 1'b1;
                n_state         = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid && !i_cfg_wr_en) begin
                    o_cmd.load_index = 1'b1;
                    n_state          = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_status.flag_result ? S_FLAG : S_LOAD;
            end
            S_FLAG: begin
                if (i_status.out_free) begin
                    o_cmd.emit_flag = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_LOAD: begin
                o_cmd.load_digit = 1'b1;
                n_div_cnt        = '0;
                n_state          = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_div_cnt = r_div_cnt + DIV_CNT_W'(1);
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_char = 1'b1;
                    n_state         = i_status.last_char ? S_IDLE : S_LOAD;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
        // Any configuration write invalidates the start and count values.
        if (i_cfg_wr_en) begin
            n_state = S_CLR;
        end
    end

    assign o_in_stall = (r_state != S_IDLE) || i_cfg_wr_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_step    <= '0;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_div_cnt <= n_div_cnt;
        end
    end

    a_cfg_restarts_recompute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> (r_state == S_CLR))
        else $error("configuration write did not restart the recompute");

    a_emit_follows_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ($past(r_state) == S_DIV || $past(r_state) == S_EMIT))
        else $error("character emitted without a completed division");

endmodule

`default_nettype wire

>>> src/index_to_phrase_enumerator.sv
// Top level of the index-to-phrase enumerator: controller and datapath.
// Sequence: accept, a range check, then per character a decrement, eight byte-division
// steps and a transfer to the output register, which waits while the output stalls.
// Throughput: one item at a time, input being stalled until the phrase is done;
// the eight-step byte divider by the radix sets the per-character cost.
// Reset and every configuration write start a recompute of the start and count
// values, during which no input transfer is taken.
`default_nettype none

module index_to_phrase_enumerator import phr_enum_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [VAL_W-1:0]     i_candidate_index,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [CHAR_W-1:0]         o_phrase_char,
    output logic                      o_last_char,
    output logic                      o_empty_phrase,
    output logic                      o_out_of_range
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    phr_enum_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd),
        .i_status   (dp_status)
    );

    phr_enum_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .i_candidate_index(i_candidate_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_phrase_char    (o_phrase_char),
        .o_last_char      (o_last_char),
        .o_empty_phrase   (o_empty_phrase),
        .o_out_of_range   (o_out_of_range)
    );

endmodule

`default_nettype wire
